FILE: rtl/hlfa_pkg.sv
// Shared types and constants for the hole-list fit allocator.
// Used by the hole chain, its slots, the divider and the top level.
package hlfa_pkg;

  localparam int MAX_HOLES        = 64;
  localparam int MAX_ALLOCS       = 64;
  localparam int MAX_REGION_WORDS = 65536;
  localparam int SCAN_LEN         = (MAX_HOLES > MAX_ALLOCS) ? MAX_HOLES : MAX_ALLOCS;

  localparam int HIDX_W  = $clog2(MAX_HOLES);
  localparam int HCNT_W  = $clog2(MAX_HOLES + 1);
  localparam int AIDX_W  = $clog2(MAX_ALLOCS);
  localparam int CNT_W   = $clog2(SCAN_LEN + 1);
  localparam int START_W = 16;
  localparam int LEN_W   = 17;
  localparam int WB_W    = 5;
  localparam int REQ_W   = 21;
  localparam int OFF_W   = 20;
  localparam int NEED_W  = REQ_W + 1;
  localparam int PROD_W  = LEN_W + WB_W;
  localparam int WB_MAX  = 16;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;

  localparam logic [1:0] CFG_WORD_BYTES   = 2'd0;
  localparam logic [1:0] CFG_REGION_WORDS = 2'd1;
  localparam logic [1:0] CFG_FIT_POLICY   = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] release_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] byte_offset;
    logic [LEN_W-1:0] granted_words;
  } out_item_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } hole_t;

  typedef enum logic [2:0] {
    HOP_NONE,
    HOP_UPD,
    HOP_REM,
    HOP_INS,
    HOP_UPD_REM
  } hole_op_e;

  typedef struct packed {
    hole_op_e          op;
    logic [HIDX_W-1:0] pos;
    hole_t             data;
  } hole_cmd_t;

endpackage

FILE: rtl/hlfa_hole_cell.sv
// One entry of the sorted hole table: takes its neighbor's entry on insert/remove.
// Also one stage of the probe line that streams entries to the head. Uses hlfa_pkg.
module hlfa_hole_cell (
  input  logic                      clk_i,
  input  logic [hlfa_pkg::HIDX_W-1:0] pos_i,
  input  hlfa_pkg::hole_cmd_t       cmd_i,
  input  hlfa_pkg::hole_t           left_i,
  input  hlfa_pkg::hole_t           right_i,
  input  logic                      probe_load_i,
  input  hlfa_pkg::hole_t           probe_i,
  output hlfa_pkg::hole_t           data_o,
  output hlfa_pkg::hole_t           probe_o
);
  import hlfa_pkg::*;

  hole_t data_q, data_d;
  hole_t probe_q, probe_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      HOP_UPD: begin
        if (pos_i == cmd_i.pos) data_d = cmd_i.data;
      end
      HOP_REM: begin
        if (pos_i >= cmd_i.pos) data_d = right_i;
      end
      HOP_INS: begin
        if (pos_i > cmd_i.pos) data_d = left_i;
        else if (pos_i == cmd_i.pos) data_d = cmd_i.data;
      end
      HOP_UPD_REM: begin
        if (pos_i > cmd_i.pos) data_d = right_i;
        else if (pos_i == cmd_i.pos) data_d = cmd_i.data;
      end
      default: ;
    endcase
    probe_d = probe_load_i ? data_q : probe_i;
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    probe_q <= probe_d;
  end

  assign data_o  = data_q;
  assign probe_o = probe_q;

endmodule

FILE: rtl/hlfa_hole_chain.sv
// Row of hole slots with neighbor links and a probe line toward slot 0.
// Depends on hlfa_pkg and hlfa_hole_cell.
module hlfa_hole_chain (
  input  logic                clk_i,
  input  hlfa_pkg::hole_cmd_t cmd_i,
  input  logic                probe_load_i,
  output hlfa_pkg::hole_t     head_probe_o
);
  import hlfa_pkg::*;

  hole_t data_w  [MAX_HOLES];
  hole_t probe_w [MAX_HOLES];

  for (genvar k = 0; k < MAX_HOLES; k++) begin : g_slot
    hole_t left_w, right_w, pin_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = data_w[k-1];
    end
    if (k == MAX_HOLES - 1) begin : g_last
      assign right_w = '0;
      assign pin_w   = '0;
    end else begin : g_inner
      assign right_w = data_w[k+1];
      assign pin_w   = probe_w[k+1];
    end
    hlfa_hole_cell u_slot (
      .clk_i        (clk_i),
      .pos_i        (HIDX_W'(k)),
      .cmd_i        (cmd_i),
      .left_i       (left_w),
      .right_i      (right_w),
      .probe_load_i (probe_load_i),
      .probe_i      (pin_w),
      .data_o       (data_w[k]),
      .probe_o      (probe_w[k])
    );
  end

  assign head_probe_o = probe_w[0];

endmodule

FILE: rtl/hlfa_divider.sv
// Restoring divider, one quotient bit per cycle: byte count by word size.
// Depends on hlfa_pkg.
module hlfa_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hlfa_pkg::REQ_W-1:0]  dividend_i,
  input  logic [hlfa_pkg::WB_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [hlfa_pkg::REQ_W-1:0]  quot_o,
  output logic                        rem_nz_o
);
  import hlfa_pkg::*;

  localparam int STEP_W = $clog2(REQ_W + 1);

  logic              active_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [REQ_W-1:0]  quot_q;
  logic [WB_W-1:0]   rem_q, dvs_q;
  logic [WB_W:0]     sh, diff;
  logic              ge;

  always_comb begin
    sh   = {rem_q, quot_q[REQ_W-1]};
    ge   = sh >= {1'b0, dvs_q};
    diff = sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      quot_q   <= '0;
      rem_q    <= '0;
      dvs_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      quot_q   <= dividend_i;
      rem_q    <= '0;
      dvs_q    <= divisor_i;
    end else if (active_q) begin
      rem_q  <= ge ? diff[WB_W-1:0] : sh[WB_W-1:0];
      quot_q <= {quot_q[REQ_W-2:0], ge};
      cnt_q  <= cnt_q + 1'b1;
      if (cnt_q == STEP_W'(REQ_W - 1)) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign rem_nz_o = rem_q != '0;

endmodule

FILE: rtl/hole_list_fit_allocator_top.sv
// Hole-list fit allocator: sequencer, allocation table and result register.
// Depends on hlfa_pkg, hlfa_hole_chain and hlfa_divider.
//
// Usage: one item on in_* (valid/ready) carries a mode: allocate, free or
// reinitialize. Each item yields exactly one result item on out_* (status,
// byte offset, words). cfg_we_i writes word_bytes, region_words or
// fit_policy by index; write only while the block is idle.
// Reinitialize and early errors are decided on acceptance and go to the result
// register. Allocate runs the bit-serial size division, then one pass over the
// hole chain (one entry per cycle at its head) with the free-slot search
// alongside, then one update step. Free makes a pass over the allocation memory
// (one read port, registered data), a pass over the hole chain and one update
// step. One item is in work at a time; in_ready_o is high between.
// Reset leaves the block uninitialized: allocate and free answer not-ready
// until a successful reinitialize. A stalled receiver holds the result in the
// output register; a finished result waits in a holding register behind it.
module hole_list_fit_allocator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hlfa_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hlfa_pkg::out_item_t               out_item_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [hlfa_pkg::LEN_W-1:0]        cfg_data_i
);
  import hlfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ASCAN, S_AAPPLY, S_FSLOT, S_FHOLE, S_FAPPLY, S_RESP
  } state_e;

  typedef enum logic [1:0] {
    KIND_LEFT, KIND_RIGHT, KIND_BEFORE
  } kind_e;

  state_e st_q, st_d;
  logic [CNT_W-1:0] j_q, j_d;

  logic [WB_W-1:0]  wb_q, wb_d;
  logic [LEN_W-1:0] region_q, region_d;
  logic             policy_q, policy_d;
  logic [LEN_W-1:0] managed_q, managed_d;
  logic             ready_q, ready_d;
  logic [HCNT_W-1:0] hcount_q, hcount_d;

  logic [OFF_W-1:0]  boff_q, boff_d;
  logic [NEED_W-1:0] need_q, need_d;

  logic              found_q, found_d;
  logic [HIDX_W-1:0] pick_idx_q, pick_idx_d;
  hole_t             pick_q, pick_d;
  logic              slot_found_q, slot_found_d;
  logic [AIDX_W-1:0] slot_q, slot_d;
  logic [START_W-1:0] s_q, s_d;
  logic [LEN_W-1:0]  len_q, len_d;

  logic              hm_found_q, hm_found_d;
  kind_e             hm_kind_q, hm_kind_d;
  logic [HIDX_W-1:0] hm_idx_q, hm_idx_d;
  hole_t             hm_hole_q, hm_hole_d;
  logic              nx_ok_q, nx_ok_d;
  hole_t             nx_q, nx_d;

  logic [MAX_ALLOCS-1:0] valid_q, valid_d;

  logic              rd_live_q, rd_live_d;
  logic [AIDX_W-1:0] rd_slot_q, rd_slot_d;
  hole_t             rd_data_q;
  logic [AIDX_W-1:0] rd_addr;
  logic              mem_we;
  hole_t             mem_wdata;
  hole_t             alloc_mem [MAX_ALLOCS];

  out_item_t res_q, res_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  hole_cmd_t cmd;
  logic      probe_load;
  hole_t     head;

  logic              div_start, div_done, div_rem_nz;
  logic [REQ_W-1:0]  div_quot;

  // scratch values
  logic [NEED_W-1:0] need_w;
  logic              fit, better, hv, hit;
  logic [LEN_W-1:0]  s17, send, hstart17, hend, nl;
  logic [PROD_W-1:0] prod;

  hlfa_hole_chain u_chain (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .probe_load_i (probe_load),
    .head_probe_o (head)
  );

  // divider samples the byte count at the accepting edge
  hlfa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_item_i.request_bytes),
    .divisor_i  (wb_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  assign in_ready_o  = st_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    st_d = st_q;         j_d = j_q;
    wb_d = wb_q;         region_d = region_q;   policy_d = policy_q;
    managed_d = managed_q; ready_d = ready_q;   hcount_d = hcount_q;
    boff_d = boff_q;     need_d = need_q;
    found_d = found_q;   pick_idx_d = pick_idx_q; pick_d = pick_q;
    slot_found_d = slot_found_q; slot_d = slot_q; s_d = s_q; len_d = len_q;
    hm_found_d = hm_found_q; hm_kind_d = hm_kind_q; hm_idx_d = hm_idx_q;
    hm_hole_d = hm_hole_q; nx_ok_d = nx_ok_q; nx_d = nx_q;
    valid_d = valid_q;
    rd_live_d = 1'b0;    rd_slot_d = rd_slot_q;
    rd_addr = j_q[AIDX_W-1:0];
    mem_we = 1'b0;       mem_wdata = '0;
    res_d = res_q;       out_d = out_q;         out_valid_d = out_valid_q;
    cmd = '{op: HOP_NONE, pos: '0, data: '0};
    probe_load = 1'b0;   div_start = 1'b0;
    need_w = '0; fit = 1'b0; better = 1'b0; hv = 1'b0; hit = 1'b0;
    s17 = {1'b0, s_q};
    send = s17 + len_q;
    hstart17 = {1'b0, head.start};
    hend = hstart17 + head.len;
    nl = '0;
    prod = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WORD_BYTES:   wb_d = cfg_data_i[WB_W-1:0];
        CFG_REGION_WORDS: region_d = cfg_data_i;
        CFG_FIT_POLICY:   policy_d = cfg_data_i[0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          boff_d  = in_item_i.release_offset;
          res_d   = '0;
          st_d    = S_RESP;
          prod    = PROD_W'(managed_q) * PROD_W'(wb_q);
          if (wb_q == '0 || wb_q > WB_W'(WB_MAX)) begin
            res_d.status = ST_INVALID;
          end else begin
            case (in_item_i.mode)
              MODE_ALLOC: begin
                if (!ready_q) res_d.status = ST_NOT_READY;
                else if (in_item_i.request_bytes == '0) res_d.status = ST_INVALID;
                else begin
                  div_start = 1'b1;
                  st_d = S_DIV;
                end
              end
              MODE_FREE: begin
                if (!ready_q) res_d.status = ST_NOT_READY;
                else if (PROD_W'(in_item_i.release_offset) >= prod)
                  res_d.status = ST_INVALID;
                else begin
                  j_d = '0;
                  slot_found_d = 1'b0;
                  st_d = S_FSLOT;
                end
              end
              MODE_INIT: begin
                if (region_q == '0 || region_q > LEN_W'(MAX_REGION_WORDS)) begin
                  res_d.status = ST_INVALID;
                end else begin
                  valid_d   = '0;
                  hcount_d  = HCNT_W'(1);
                  cmd       = '{op: HOP_UPD, pos: '0, data: '{start: '0, len: region_q}};
                  managed_d = region_q;
                  ready_d   = 1'b1;
                  res_d.status = ST_OK;
                  res_d.granted_words = region_q;
                end
              end
              default: res_d.status = ST_INVALID;
            endcase
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          need_w = NEED_W'(div_quot) + NEED_W'(div_rem_nz);
          need_d = need_w;
          if (need_w > NEED_W'(managed_q)) begin
            res_d.status = ST_INVALID;
            st_d = S_RESP;
          end else begin
            probe_load   = 1'b1;
            j_d          = '0;
            found_d      = 1'b0;
            slot_found_d = 1'b0;
            st_d         = S_ASCAN;
          end
        end
      end

      S_ASCAN: begin
        hv = (j_q < CNT_W'(MAX_HOLES)) && (j_q < CNT_W'(hcount_q));
        fit = NEED_W'(head.len) >= need_q;
        better = policy_q ? (head.len > pick_q.len) : (head.len < pick_q.len);
        if (hv && fit && (!found_q || better)) begin
          found_d    = 1'b1;
          pick_d     = head;
          pick_idx_d = j_q[HIDX_W-1:0];
        end
        if (j_q < CNT_W'(MAX_ALLOCS) && !slot_found_q && !valid_q[j_q[AIDX_W-1:0]]) begin
          slot_found_d = 1'b1;
          slot_d       = j_q[AIDX_W-1:0];
        end
        j_d = j_q + 1'b1;
        if (j_q == CNT_W'(SCAN_LEN - 1)) st_d = S_AAPPLY;
      end

      S_AAPPLY: begin
        st_d = S_RESP;
        if (!found_q) res_d.status = ST_INVALID;
        else if (!slot_found_q) res_d.status = ST_FULL;
        else begin
          valid_d[slot_q] = 1'b1;
          mem_we    = 1'b1;
          rd_addr   = slot_q;
          mem_wdata = '{start: pick_q.start, len: need_q[LEN_W-1:0]};
          prod      = PROD_W'(pick_q.start) * PROD_W'(wb_q);
          nl        = pick_q.len - need_q[LEN_W-1:0];
          if (nl == '0) begin
            cmd = '{op: HOP_REM, pos: pick_idx_q, data: '0};
            hcount_d = hcount_q - HCNT_W'(1);
          end else begin
            cmd = '{op: HOP_UPD, pos: pick_idx_q,
                    data: '{start: pick_q.start + need_q[START_W-1:0], len: nl}};
          end
          res_d.status        = ST_OK;
          res_d.byte_offset   = prod[OFF_W-1:0];
          res_d.granted_words = need_q[LEN_W-1:0];
        end
      end

      S_FSLOT: begin
        // read issued this cycle, compared next cycle
        rd_live_d = j_q < CNT_W'(MAX_ALLOCS);
        rd_slot_d = j_q[AIDX_W-1:0];
        prod = PROD_W'(rd_data_q.start) * PROD_W'(wb_q);
        hit = rd_live_q && valid_q[rd_slot_q] && !slot_found_q &&
              (prod == PROD_W'(boff_q));
        if (hit) begin
          slot_found_d = 1'b1;
          slot_d       = rd_slot_q;
          s_d          = rd_data_q.start;
          len_d        = rd_data_q.len;
        end
        j_d = j_q + 1'b1;
        if (j_q == CNT_W'(MAX_ALLOCS)) begin
          if (slot_found_q || hit) begin
            probe_load = 1'b1;
            j_d        = '0;
            hm_found_d = 1'b0;
            nx_ok_d    = 1'b0;
            st_d       = S_FHOLE;
          end else begin
            res_d.status = ST_INVALID;
            st_d = S_RESP;
          end
        end
      end

      S_FHOLE: begin
        hv = (j_q < CNT_W'(MAX_HOLES)) && (j_q < CNT_W'(hcount_q));
        if (hv && !hm_found_q) begin
          if (hend == s17) begin
            hm_found_d = 1'b1; hm_kind_d = KIND_LEFT;
          end else if (hstart17 == send) begin
            hm_found_d = 1'b1; hm_kind_d = KIND_RIGHT;
          end else if (s17 < hstart17) begin
            hm_found_d = 1'b1; hm_kind_d = KIND_BEFORE;
          end
          hm_idx_d  = j_q[HIDX_W-1:0];
          hm_hole_d = head;
        end
        // right neighbor of a left merge
        if (hv && hm_found_q && hm_kind_q == KIND_LEFT &&
            j_q == CNT_W'(hm_idx_q) + CNT_W'(1)) begin
          nx_ok_d = 1'b1;
          nx_d    = head;
        end
        j_d = j_q + 1'b1;
        if (j_q == CNT_W'(MAX_HOLES - 1)) st_d = S_FAPPLY;
      end

      S_FAPPLY: begin
        st_d = S_RESP;
        res_d.status        = ST_OK;
        res_d.granted_words = len_q;
        if (hm_found_q && hm_kind_q == KIND_LEFT) begin
          nl = hm_hole_q.len + len_q;
          if (nx_ok_q && {1'b0, nx_q.start} == send) begin
            nl = nl + nx_q.len;
            cmd = '{op: HOP_UPD_REM, pos: hm_idx_q, data: '{start: hm_hole_q.start, len: nl}};
            hcount_d = hcount_q - HCNT_W'(1);
          end else begin
            cmd = '{op: HOP_UPD, pos: hm_idx_q, data: '{start: hm_hole_q.start, len: nl}};
          end
        end else if (hm_found_q && hm_kind_q == KIND_RIGHT) begin
          cmd = '{op: HOP_UPD, pos: hm_idx_q, data: '{start: s_q, len: hm_hole_q.len + len_q}};
        end else if (hcount_q == HCNT_W'(MAX_HOLES)) begin
          res_d.status        = ST_FULL;
          res_d.granted_words = '0;
        end else begin
          cmd = '{op: HOP_INS, pos: hm_found_q ? hm_idx_q : hcount_q[HIDX_W-1:0],
                  data: '{start: s_q, len: len_q}};
          hcount_d = hcount_q + HCNT_W'(1);
        end
        if (res_d.status == ST_OK) valid_d[slot_q] = 1'b0;
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;      j_q <= '0;
      wb_q <= WB_W'(8);    region_q <= '0;   policy_q <= 1'b0;
      managed_q <= '0;     ready_q <= 1'b0;  hcount_q <= '0;
      boff_q <= '0;        need_q <= '0;
      found_q <= 1'b0;     pick_idx_q <= '0; pick_q <= '0;
      slot_found_q <= 1'b0; slot_q <= '0;    s_q <= '0;      len_q <= '0;
      hm_found_q <= 1'b0;  hm_kind_q <= KIND_LEFT; hm_idx_q <= '0;
      hm_hole_q <= '0;     nx_ok_q <= 1'b0;  nx_q <= '0;
      valid_q <= '0;
      rd_live_q <= 1'b0;   rd_slot_q <= '0;
      res_q <= '0;         out_q <= '0;      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;        j_q <= j_d;
      wb_q <= wb_d;        region_q <= region_d; policy_q <= policy_d;
      managed_q <= managed_d; ready_q <= ready_d; hcount_q <= hcount_d;
      boff_q <= boff_d;    need_q <= need_d;
      found_q <= found_d;  pick_idx_q <= pick_idx_d; pick_q <= pick_d;
      slot_found_q <= slot_found_d; slot_q <= slot_d; s_q <= s_d; len_q <= len_d;
      hm_found_q <= hm_found_d; hm_kind_q <= hm_kind_d; hm_idx_q <= hm_idx_d;
      hm_hole_q <= hm_hole_d; nx_ok_q <= nx_ok_d; nx_q <= nx_d;
      valid_q <= valid_d;
      rd_live_q <= rd_live_d; rd_slot_q <= rd_slot_d;
      res_q <= res_d;      out_q <= out_d;   out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) alloc_mem[rd_addr] <= mem_wdata;
    rd_data_q <= alloc_mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_hcount_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcount_q <= HCNT_W'(MAX_HOLES))
    else $error("hole count above table size");

  a_uninit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_q |-> (hcount_q == '0 && valid_q == '0))
    else $error("tables in use before initialization");

  a_ok_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_OK) |-> out_q.granted_words != '0)
    else $error("successful item with zero words");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |->
      (out_q.byte_offset == '0 && out_q.granted_words == '0))
    else $error("failed item carries payload");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> st_q != S_IDLE)
    else $error("accepted item not taken into work");
`endif

endmodule
